FILE: design/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg: shared types and constants for the string stencil block
// Grid size, value format, request/response payloads, command and mode codes,
// and the saturation helpers used by the sequencer and the stencil unit.
// ----------------------------------------------------------------------------
package wss_pkg;

  // Grid geometry and value format (signed Q2.22 by default)
  localparam int POINTS     = 256;
  localparam int VALUE_BITS = 24;
  localparam int IDX_W      = $clog2(POINTS);
  localparam int CNT_W      = $clog2(POINTS + 1);

  // Port field widths
  localparam int CMD_W      = 2;
  localparam int IN_IDX_W   = 8;
  localparam int IO_W       = 24;
  localparam int GAIN_W     = 17;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;

  // Arithmetic widths: laplacian, gain product, and a roomy sum
  localparam int FRAC_W     = 16;
  localparam int DIFF_W     = VALUE_BITS + 2;
  localparam int PROD_W     = GAIN_W + 1 + DIFF_W;
  localparam int WIDE_W     = PROD_W + 1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);

  localparam logic signed [WIDE_W-1:0] ROUND_W   = WIDE_W'(64'sd1 <<< (FRAC_W - 1));
  localparam logic signed [WIDE_W-1:0] VAL_MAX_W =
    WIDE_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [WIDE_W-1:0] VAL_MIN_W = ~VAL_MAX_W;
  localparam logic signed [WIDE_W-1:0] OUT_MAX_W =
    WIDE_W'((64'sd1 <<< (IO_W - 1)) - 64'sd1);
  localparam logic signed [WIDE_W-1:0] OUT_MIN_W = ~OUT_MAX_W;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_STEP = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  // Right end behavior
  typedef enum logic [MODE_W-1:0] {
    MODE_FIXED  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_DRIVEN = 2'd2
  } mode_e;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN = 1'b0,
    CFG_MODE = 1'b1
  } cfg_reg_e;

  // How the stencil unit forms a point's new value
  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_INNER = 2'd1,
    SEL_FREE  = 2'd2,
    SEL_DRIVE = 2'd3
  } pt_sel_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RDWAIT = 2'd1,
    ST_SWEEP  = 2'd2,
    ST_DRAIN  = 2'd3
  } state_e;

  // Request and response payloads
  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [IN_IDX_W-1:0]    point_index;
    logic signed [IO_W-1:0] load_value;
    logic signed [IO_W-1:0] drive_value;
  } wss_in_t;

  typedef struct packed {
    logic signed [IO_W-1:0] read_value;
    logic                   read_valid;
  } wss_out_t;

  // Point issued to the stencil unit
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    pt_sel_e          sel;
  } wss_pt_ctl_t;

  // Grid write-back from the stencil unit
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } wss_wr_t;

  // Clamp to the grid value range
  function automatic logic signed [VALUE_BITS-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = v;
    if (v > VAL_MAX_W) c = VAL_MAX_W;
    if (v < VAL_MIN_W) c = VAL_MIN_W;
    return VALUE_BITS'(c);
  endfunction

  // Clamp to the 24-bit port range
  function automatic logic signed [IO_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = v;
    if (v > OUT_MAX_W) c = OUT_MAX_W;
    if (v < OUT_MIN_W) c = OUT_MIN_W;
    return IO_W'(c);
  endfunction

endpackage

FILE: design/wave_string_stencil_step.sv
// ----------------------------------------------------------------------------
// wave_string_stencil_step: 1-D wave equation leapfrog stepper
// Holds the current and previous displacement grids and advances them with
// an explicit finite-difference stencil on command.
// ----------------------------------------------------------------------------
// A load or an unused command is answered straight from idle and a read
// after its registered memory read; a step runs a sweep that reads one
// grid point per cycle from the current/previous grid memories and feeds
// the three-stage stencil unit, followed by its pipeline drain.
// The block takes one request at a time and is not ready until the previous
// request has finished and its response slot is free or being emptied.
// Grid entries read as zero until first written, so no clearing pass runs
// after reset. Configuration writes are taken every cycle.
module wave_string_stencil_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  wss_pkg::wss_in_t                  in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output wss_pkg::wss_out_t                 out_rsp_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wss_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wss_pkg::GAIN_W-1:0]        cfg_data_i
);
  import wss_pkg::*;

  // Grid memories and written-once flags
  logic signed [VALUE_BITS-1:0] cur_mem  [POINTS];
  logic signed [VALUE_BITS-1:0] prev_mem [POINTS];
  logic [POINTS-1:0]            vld_q;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     s1_vld_q;
  logic [CNT_W-1:0]         s1_tag_q;
  logic signed [VALUE_BITS-1:0] win_cur_q, win_prev_q, hold_q;
  logic signed [VALUE_BITS-1:0] drive_q, drive_d;
  logic [GAIN_W-1:0]        gain_q;
  logic [MODE_W-1:0]        mode_q;
  logic                     cmd_ok_q, cmd_ok_d;
  logic                     out_vld_q, out_vld_d;
  wss_out_t                 out_rsp_q, out_rsp_d;

  logic                     in_fire, cfg_fire, idx_ok;
  logic [IDX_W-1:0]         in_addr, rd_addr, wr_addr;
  logic                     load_we, mem_we;
  logic signed [VALUE_BITS-1:0] load_sat, wr_cur, wr_prev;
  logic signed [VALUE_BITS-1:0] rd_cur_q, rd_prev_q, cur_eff, prev_eff;
  logic                     rd_ok_q;

  wss_pt_ctl_t              issue;
  wss_wr_t                  unit_wr;
  logic signed [VALUE_BITS-1:0] unit_new, unit_old;

  // Handshakes
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_vld_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

  // Request decode
  assign idx_ok   = int'(in_req_i.point_index) < POINTS;
  assign in_addr  = IDX_W'(in_req_i.point_index);
  assign load_sat = sat_val(WIDE_W'(in_req_i.load_value));
  assign load_we  = in_fire && (in_req_i.cmd == CMD_LOAD) && idx_ok;

  // Memory port muxing: sweep owns the ports while stepping
  assign rd_addr = (state_q == ST_SWEEP) ? cnt_q[IDX_W-1:0] : in_addr;
  always_comb begin
    mem_we  = unit_wr.vld || load_we;
    wr_addr = unit_wr.vld ? unit_wr.idx : in_addr;
    wr_cur  = unit_wr.vld ? unit_new : load_sat;
    wr_prev = unit_wr.vld ? unit_old : load_sat;
  end

  // Grid memories, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cur_mem[wr_addr]  <= wr_cur;
      prev_mem[wr_addr] <= wr_prev;
    end
    rd_cur_q  <= cur_mem[rd_addr];
    rd_prev_q <= prev_mem[rd_addr];
    rd_ok_q   <= vld_q[rd_addr];
  end

  // Entries never written read as zero
  assign cur_eff  = rd_ok_q ? rd_cur_q : '0;
  assign prev_eff = rd_ok_q ? rd_prev_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // Window stage: point j = tag-1 is issued once its right neighbor arrives
  always_comb begin
    issue.vld = s1_vld_q && (s1_tag_q != '0);
    issue.idx = IDX_W'(s1_tag_q - CNT_W'(1));
    if (s1_tag_q == CNT_W'(1)) begin
      issue.sel = SEL_ZERO;
    end else if (s1_tag_q == CNT_W'(POINTS)) begin
      case (mode_q)
        MODE_FREE:   issue.sel = SEL_FREE;
        MODE_DRIVEN: issue.sel = SEL_DRIVE;
        default:     issue.sel = SEL_ZERO;
      endcase
    end else begin
      issue.sel = SEL_INNER;
    end
  end

  wss_stencil_unit u_stencil (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .left_i    (hold_q),
    .old_i     (win_cur_q),
    .right_i   (cur_eff),
    .prev_i    (win_prev_q),
    .drive_i   (drive_q),
    .gain_i    (gain_q),
    .wr_o      (unit_wr),
    .new_val_o (unit_new),
    .old_val_o (unit_old)
  );

  // Window data
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      win_cur_q  <= cur_eff;
      win_prev_q <= prev_eff;
    end
  end

  // Left neighbor hold: old value of the point just issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else if (issue.vld) begin
      hold_q <= win_cur_q;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      mode_q <= MODE_FIXED;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        CFG_GAIN: gain_q <= cfg_data_i;
        CFG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        default:  ;
      endcase
    end
  end

  // Sequencer: next state and response
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    drive_d   = drive_q;
    cmd_ok_d  = cmd_ok_q;
    out_vld_d = out_vld_q && !out_ready_i;
    out_rsp_d = out_rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req_i.cmd)
            CMD_STEP: begin
              drive_d = sat_val(WIDE_W'(in_req_i.drive_value));
              cnt_d   = '0;
              state_d = ST_SWEEP;
            end
            CMD_READ: begin
              cmd_ok_d = idx_ok;
              state_d  = ST_RDWAIT;
            end
            default: begin
              // load and unused command answer at once
              out_vld_d            = 1'b1;
              out_rsp_d.read_value = '0;
              out_rsp_d.read_valid = 1'b0;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        out_vld_d            = 1'b1;
        out_rsp_d.read_value = cmd_ok_q ? sat_out(WIDE_W'(cur_eff)) : '0;
        out_rsp_d.read_valid = 1'b1;
        state_d              = ST_IDLE;
      end
      ST_SWEEP: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(POINTS)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (unit_wr.vld && (unit_wr.idx == IDX_W'(POINTS - 1))) begin
          out_vld_d            = 1'b1;
          out_rsp_d.read_value = '0;
          out_rsp_d.read_valid = 1'b0;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      s1_vld_q  <= 1'b0;
      s1_tag_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      s1_vld_q  <= (state_q == ST_SWEEP);
      s1_tag_q  <= cnt_q;
      out_vld_q <= out_vld_d;
    end
  end

  // Sequencer payload registers
  always_ff @(posedge clk_i) begin
    drive_q   <= drive_d;
    cmd_ok_q  <= cmd_ok_d;
    out_rsp_q <= out_rsp_d;
  end

  // Grid write-back only comes from a step in progress
  a_wr_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_wr.vld |-> (state_q == ST_SWEEP) || (state_q == ST_DRAIN))
    else $error("stencil write-back outside a step");

  // Sweep writes points in ascending order
  a_wr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_wr.vld && $past(unit_wr.vld) |-> unit_wr.idx == IDX_W'($past(unit_wr.idx) + 1'b1))
    else $error("stencil write-back out of order");

  // A request is only taken when its response slot will be free
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !out_vld_q || out_ready_i)
    else $error("request accepted with response slot busy");

  // A finished step answers with read_valid low
  a_step_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && $past(state_q == ST_DRAIN) |-> out_vld_q && !out_rsp_q.read_valid)
    else $error("step finished without its response");

endmodule

FILE: design/wss_stencil_unit.sv
// ----------------------------------------------------------------------------
// wss_stencil_unit: shared leapfrog update unit
// Three-stage pipeline reused for every grid point of a sweep: laplacian,
// gain multiply, then rounding, leapfrog sum and saturation.
// ----------------------------------------------------------------------------
module wss_stencil_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wss_pkg::wss_pt_ctl_t                  issue_i,
  input  logic signed [wss_pkg::VALUE_BITS-1:0] left_i,
  input  logic signed [wss_pkg::VALUE_BITS-1:0] old_i,
  input  logic signed [wss_pkg::VALUE_BITS-1:0] right_i,
  input  logic signed [wss_pkg::VALUE_BITS-1:0] prev_i,
  input  logic signed [wss_pkg::VALUE_BITS-1:0] drive_i,
  input  logic [wss_pkg::GAIN_W-1:0]            gain_i,
  output wss_pkg::wss_wr_t                      wr_o,
  output logic signed [wss_pkg::VALUE_BITS-1:0] new_val_o,
  output logic signed [wss_pkg::VALUE_BITS-1:0] old_val_o
);
  import wss_pkg::*;

  wss_pt_ctl_t              ctl1_q, ctl2_q;
  logic signed [DIFF_W-1:0] diff_d, diff_q;
  logic signed [DIFF_W-1:0] base_d, base1_q, base2_q;
  logic signed [VALUE_BITS-1:0] old1_q, old2_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [GAIN_W:0]   gain_s;
  logic signed [DIFF_W-1:0] left_x, old_x, right_x, prev_x;
  logic signed [WIDE_W-1:0] term_w, sum_w;

  // Stage 1: laplacian (one-sided at a free end) and 2*cur - prev
  always_comb begin
    left_x  = DIFF_W'(left_i);
    old_x   = DIFF_W'(old_i);
    right_x = DIFF_W'(right_i);
    prev_x  = DIFF_W'(prev_i);
    if (issue_i.sel == SEL_FREE) begin
      diff_d = left_x - old_x;
    end else begin
      diff_d = right_x + left_x - (old_x <<< 1);
    end
    base_d = (old_x <<< 1) - prev_x;
  end

  // Stage 2: gain times laplacian, exact
  always_comb begin
    gain_s = {1'b0, gain_i};
    prod_d = gain_s * diff_q;
  end

  // Stage 3: round to nearest (ties up), add, saturate; zero and drive points take zero or the drive value
  always_comb begin
    term_w = (WIDE_W'(prod_q) + ROUND_W) >>> FRAC_W;
    sum_w  = term_w + WIDE_W'(base2_q);
    case (ctl2_q.sel)
      SEL_ZERO:  new_val_o = '0;
      SEL_DRIVE: new_val_o = drive_i;
      default:   new_val_o = sat_val(sum_w);
    endcase
    old_val_o = old2_q;
    wr_o.vld  = ctl2_q.vld;
    wr_o.idx  = ctl2_q.idx;
  end

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= issue_i;
      ctl2_q <= ctl1_q;
    end
  end

  // Pipeline data
  always_ff @(posedge clk_i) begin
    diff_q  <= diff_d;
    base1_q <= base_d;
    old1_q  <= old_i;
    prod_q  <= prod_d;
    base2_q <= base1_q;
    old2_q  <= old1_q;
  end

endmodule

FILE: tb/wave_string_stencil_step_tb.sv
// ----------------------------------------------------------------------------
// wave_string_stencil_step_tb: self-checking bench for the string stepper
// Drives load, step, read and unused commands through the request channel.
// A directed list covers reset contents, value extremes, the pinned ends and
// the unused command. Random pluck/evolve/probe sequences follow under
// several gain and right-end settings. Responses are checked against an in-bench
// copy of both grids, updated on every accepted request, or a hand-written value.
// ----------------------------------------------------------------------------
module wave_string_stencil_step_tb;
  import wss_pkg::*;

  localparam int HALF_PERIOD     = 2;
  localparam int RESET_CYCLES    = 4;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int SETTLE_CYCLES   = 12;    // block is idle this long after its last response
  localparam int QUIET_LIMIT     = 4000;  // longer than a whole step, sweep and drain, plus stalls
  localparam int REPORT_LIMIT    = 10;

  localparam logic [CMD_W-1:0]  CMD_SPARE  = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam logic signed [IO_W-1:0] IO_TOP    = 24'sh7FFFFF;
  localparam logic signed [IO_W-1:0] IO_BOTTOM = 24'sh800000;
  localparam logic signed [IO_W-1:0] Q_ONE     = 24'sh400000;

  localparam longint GRID_TOP    = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
  localparam longint GRID_BOTTOM = -GRID_TOP - 64'sd1;
  localparam longint OUT_TOP     = (64'sd1 <<< (IO_W - 1)) - 64'sd1;
  localparam longint OUT_BOTTOM  = -OUT_TOP - 64'sd1;
  localparam longint ROUND_HALF  = 64'sd1 <<< (FRAC_W - 1);

  // Clock, reset and block ports
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  wss_in_t               in_req_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  wss_out_t              out_rsp_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_GAIN;
  logic [GAIN_W-1:0]     cfg_data_i  = '0;

  wave_string_stencil_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Bench copy of the string state and settings
  logic signed [VALUE_BITS-1:0] disp_now [POINTS];
  logic signed [VALUE_BITS-1:0] disp_old [POINTS];
  logic [GAIN_W-1:0]            k_gain;
  logic [MODE_W-1:0]            end_mode;

  // Directed requests, with a hand-written response where it is obvious
  typedef struct {
    wss_in_t  req;
    bit       typed;
    wss_out_t rsp;
  } plan_row_t;

  plan_row_t   plan_rows [$];
  wss_out_t    rsp_due [$];
  int unsigned errors;
  int unsigned checked;
  int unsigned useful_items;
  int unsigned cmd_seen [4];
  int unsigned quiet_cycles;
  int unsigned sink_hold;
  bit          idle_on;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // k * laplacian with k in unsigned Q1.16, rounded to nearest with ties upward
  function automatic longint stencil_pull(input longint diff);
    return (longint'(k_gain) * diff + ROUND_HALF) >>> FRAC_W;
  endfunction

  // One leapfrog sweep, left to right, in place
  function automatic void advance_grid(input longint drive);
    longint left, mid, past, nv;
    left = 0;
    for (int j = 0; j < POINTS; j++) begin
      mid  = disp_now[j];
      past = disp_old[j];
      if (j == 0) begin
        nv = 0;
      end else if (j == POINTS - 1) begin
        if (end_mode == MODE_FREE) nv = stencil_pull(left - mid) + 2 * mid - past;
        else if (end_mode == MODE_DRIVEN) nv = drive;
        else nv = 0;
      end else begin
        nv = stencil_pull(longint'(disp_now[j + 1]) + left - 2 * mid) + 2 * mid - past;
      end
      disp_old[j] = VALUE_BITS'(mid);
      disp_now[j] = VALUE_BITS'(clip(nv, GRID_BOTTOM, GRID_TOP));
      left = mid;
    end
  endfunction

  // Update the bench grids for one request and return its response
  function automatic wss_out_t apply_request(input wss_in_t req);
    wss_out_t rsp;
    rsp = '0;
    case (req.cmd)
      CMD_LOAD: begin
        if (req.point_index < POINTS) begin
          disp_now[req.point_index] =
            VALUE_BITS'(clip(longint'(req.load_value), GRID_BOTTOM, GRID_TOP));
          disp_old[req.point_index] = disp_now[req.point_index];
        end
      end
      CMD_STEP: advance_grid(clip(longint'(req.drive_value), GRID_BOTTOM, GRID_TOP));
      CMD_READ: begin
        rsp.read_valid = 1'b1;
        if (req.point_index < POINTS)
          rsp.read_value =
            IO_W'(clip(longint'(disp_now[req.point_index]), OUT_BOTTOM, OUT_TOP));
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic void plan_row(input logic [CMD_W-1:0] c, input logic [IN_IDX_W-1:0] idx,
                                   input logic signed [IO_W-1:0] ld,
                                   input logic signed [IO_W-1:0] dr, input bit typed,
                                   input logic signed [IO_W-1:0] val, input logic vld);
    plan_row_t row;
    row.req.cmd            = c;
    row.req.point_index    = idx;
    row.req.load_value     = ld;
    row.req.drive_value    = dr;
    row.typed              = typed;
    row.rsp.read_value     = val;
    row.rsp.read_valid     = vld;
    plan_rows.push_back(row);
  endfunction

  // Grid point, leaning toward the two ends
  function automatic logic [IN_IDX_W-1:0] pick_point();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return IN_IDX_W'(POINTS - 1);
      2:       return IN_IDX_W'(POINTS - 2);
      3:       return 8'd1;
      default: return IN_IDX_W'($urandom);
    endcase
  endfunction

  // Displacement: extremes, small values or anything
  function automatic logic signed [IO_W-1:0] pick_disp();
    case ($urandom_range(0, 5))
      0:       return IO_TOP;
      1:       return IO_BOTTOM;
      2:       return IO_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      default: return IO_W'($urandom);
    endcase
  endfunction

  function automatic wss_in_t random_req(input logic [CMD_W-1:0] c);
    wss_in_t req;
    req.cmd         = c;
    req.point_index = pick_point();
    req.load_value  = pick_disp();
    req.drive_value = pick_disp();
    return req;
  endfunction

  task automatic note_error(input string what);
    errors++;
    if (errors <= REPORT_LIMIT) $display("mismatch: %s", what);
  endtask

  // Present one request, hold it until taken, then record its response
  task automatic send_req(input wss_in_t req, input bit typed, input wss_out_t typed_rsp);
    wss_out_t want;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = apply_request(req);
    if (typed) want = typed_rsp;
    rsp_due.push_back(want);
    cmd_seen[req.cmd]++;
    if (req.cmd != CMD_SPARE) useful_items++;
  endtask

  // Stop sending until every response is back and the block has settled
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back, valid held high between them
  task automatic write_regs(input logic [GAIN_W-1:0] gain, input logic [MODE_W-1:0] mode);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_GAIN;
    cfg_data_i  <= gain;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    k_gain = gain;
    cfg_index_i <= CFG_MODE;
    cfg_data_i  <= GAIN_W'(mode);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    end_mode = mode;
    cfg_valid_i <= 1'b0;
  endtask

  // Response side: ready drops in random bursts while idling is on
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold   <= sink_hold - 1;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      sink_hold   <= $urandom_range(1, 15) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each response with the oldest one outstanding
  always @(posedge clk_i) begin
    wss_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_due.size() == 0) begin
        note_error($sformatf("response value %h valid %b with nothing outstanding",
                             out_rsp_o.read_value, out_rsp_o.read_valid));
      end else begin
        want = rsp_due.pop_front();
        checked++;
        if (out_rsp_o.read_value !== want.read_value)
          note_error($sformatf("read_value expected %h got %h",
                               want.read_value, out_rsp_o.read_value));
        if (out_rsp_o.read_valid !== want.read_valid)
          note_error($sformatf("read_valid expected %b got %b",
                               want.read_valid, out_rsp_o.read_valid));
      end
    end
  end

  // Watchdog: any request, response or register write restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    int unsigned       phase_start;
    int unsigned       n;
    logic [GAIN_W-1:0] gain;
    logic [MODE_W-1:0] mode;
    wss_out_t          no_rsp;

    no_rsp  = '0;
    idle_on = 1'b1;
    for (int j = 0; j < POINTS; j++) begin
      disp_now[j] = '0;
      disp_old[j] = '0;
    end

    // Reset contents, extremes, pinned ends, unused command
    plan_row(CMD_READ,  8'd0,   '0,        '0,        1'b1, '0,        1'b1);
    plan_row(CMD_READ,  8'd255, '0,        '0,        1'b1, '0,        1'b1);
    plan_row(CMD_SPARE, 8'd255, IO_TOP,    IO_BOTTOM, 1'b1, '0,        1'b0);
    plan_row(CMD_LOAD,  8'd0,   IO_TOP,    IO_BOTTOM, 1'b1, '0,        1'b0);
    plan_row(CMD_LOAD,  8'd255, IO_BOTTOM, IO_TOP,    1'b1, '0,        1'b0);
    plan_row(CMD_READ,  8'd0,   '0,        '0,        1'b1, IO_TOP,    1'b1);
    plan_row(CMD_READ,  8'd255, '0,        '0,        1'b1, IO_BOTTOM, 1'b1);
    plan_row(CMD_LOAD,  8'd128, Q_ONE,     '0,        1'b1, '0,        1'b0);
    plan_row(CMD_LOAD,  8'd127, -24'sd1,   '0,        1'b1, '0,        1'b0);
    plan_row(CMD_LOAD,  8'd129, IO_TOP,    '0,        1'b1, '0,        1'b0);
    plan_row(CMD_LOAD,  8'd1,   IO_BOTTOM, '0,        1'b1, '0,        1'b0);
    plan_row(CMD_STEP,  8'd0,   '0,        IO_TOP,    1'b1, '0,        1'b0);
    plan_row(CMD_READ,  8'd0,   '0,        '0,        1'b1, '0,        1'b1);
    plan_row(CMD_READ,  8'd255, '0,        '0,        1'b1, '0,        1'b1);
    plan_row(CMD_READ,  8'd128, '0,        '0,        1'b0, '0,        1'b0);
    plan_row(CMD_READ,  8'd127, '0,        '0,        1'b0, '0,        1'b0);
    plan_row(CMD_READ,  8'd129, '0,        '0,        1'b0, '0,        1'b0);
    plan_row(CMD_READ,  8'd1,   '0,        '0,        1'b0, '0,        1'b0);
    plan_row(CMD_READ,  8'd2,   '0,        '0,        1'b0, '0,        1'b0);
    plan_row(CMD_STEP,  8'd0,   '0,        IO_BOTTOM, 1'b1, '0,        1'b0);
    plan_row(CMD_READ,  8'd128, '0,        '0,        1'b0, '0,        1'b0);
    plan_row(CMD_READ,  8'd254, '0,        '0,        1'b0, '0,        1'b0);
    plan_row(CMD_LOAD,  8'd200, 24'sh123456, '0,      1'b1, '0,        1'b0);
    plan_row(CMD_READ,  8'd200, '0,        '0,        1'b1, 24'sh123456, 1'b1);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings, written out explicitly
    write_regs(GAIN_RESET, MODE_FIXED);
    foreach (plan_rows[r]) send_req(plan_rows[r].req, plan_rows[r].typed, plan_rows[r].rsp);

    // Random part: one gain / right-end setting per phase
    for (int phase = 0; phase < PHASES; phase++) begin
      hold_until_drained();
      case (phase)
        0:       begin gain = GAIN_RESET;                        mode = MODE_FREE;   end
        1:       begin gain = 17'd65536;                         mode = MODE_DRIVEN; end
        2:       begin gain = '0;                                mode = MODE_FIXED;  end
        3:       begin gain = '1;                                mode = MODE_SPARE;  end
        4:       begin gain = 17'd1;                             mode = MODE_FREE;   end
        5:       begin gain = GAIN_W'($urandom_range(0, 65536)); mode = MODE_DRIVEN; end
        6:       begin gain = 17'd65535;                         mode = MODE_FREE;   end
        default: begin gain = GAIN_RESET;                        mode = MODE_FIXED;  end
      endcase
      idle_on = (phase != 2) && (phase != PHASES - 1);
      write_regs(gain, mode);
      phase_start = useful_items;
      while (useful_items - phase_start < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 7) begin
          // pluck a few points, let the string evolve, probe it
          n = $urandom_range(1, 6);
          repeat (n) send_req(random_req(CMD_LOAD), 1'b0, no_rsp);
          n = $urandom_range(1, 3);
          repeat (n) send_req(random_req(CMD_STEP), 1'b0, no_rsp);
          n = $urandom_range(2, 6);
          repeat (n) send_req(random_req(CMD_READ), 1'b0, no_rsp);
        end else begin
          // loose requests, unused command included
          n = $urandom_range(1, 4);
          repeat (n) send_req(random_req(CMD_W'($urandom_range(0, 3))), 1'b0, no_rsp);
        end
        if ($urandom_range(0, 39) == 0) hold_until_drained();
      end
    end

    hold_until_drained();
    if (rsp_due.size() != 0)
      note_error($sformatf("%0d responses never arrived", rsp_due.size()));

    $display("covered %0d loads, %0d steps, %0d reads, %0d unused commands over %0d settings",
             cmd_seen[CMD_LOAD], cmd_seen[CMD_STEP], cmd_seen[CMD_READ], cmd_seen[CMD_SPARE],
             PHASES + 1);
    $display("%0d responses compared, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/wss_pkg.sv
design/wss_stencil_unit.sv
design/wave_string_stencil_step.sv
tb/wave_string_stencil_step_tb.sv
